// ===== rtl/shgk_pkg.sv =====
// Package for the spatial hash grid key core: widths, register indexes and
// shared types. No dependencies.
package shgk_pkg;

	localparam int RES_BITS  = 10;
	localparam int RES_W     = RES_BITS + 1;
	localparam int POS_W     = 32;
	localparam int KEY_W     = 30;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RES_X   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RES_Y   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RES_Z   = 2'd3;

	typedef logic [RES_W-1:0] res_t;

	// Clamp a resolution register to 1..2^RES_BITS.
	function automatic res_t eff_res(input logic [10:0] r);
		res_t max_r;
		max_r = res_t'(1) << RES_BITS;
		if (r == 11'd0)
			eff_res = res_t'(1);
		else if ({21'd0, r} > 32'(max_r))
			eff_res = max_r;
		else
			eff_res = res_t'(r);
	endfunction

endpackage

// ===== rtl/shgk_div.sv =====
// Pipelined signed floor divider: 32-bit signed numerator by 32-bit unsigned
// divisor, one restoring quotient bit per stage. Uses shgk_pkg.
module shgk_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [shgk_pkg::POS_W-1:0] num,
	input  logic [31:0]                       den,
	output logic signed [shgk_pkg::POS_W-1:0] quo
);
	import shgk_pkg::*;

	localparam int N = POS_W;

	// per-stage state: magnitude remainder, shifting dividend/quotient, sign
	logic [N-1:0] rem_s [N];
	logic [N-1:0] dq_s  [N];
	logic [N-1:0] den_s [N-1];
	logic         neg_s [N];

	logic [31:0] mag;
	assign mag = num[N-1] ? (32'd0 - num) : num;

	// shift in one dividend bit, subtract the divisor when it fits
	function automatic logic [2*N-1:0] div_step(input logic [N-1:0] r,
			input logic [N-1:0] dq, input logic [N-1:0] dv);
		logic [N:0] sh;
		logic [N:0] trial;
		sh    = {r, dq[N-1]};
		trial = sh - {1'b0, dv};
		if (trial[N])
			div_step = {sh[N-1:0], dq[N-2:0], 1'b0};
		else
			div_step = {trial[N-1:0], dq[N-2:0], 1'b1};
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			{rem_s[0], dq_s[0]} <= div_step('0, mag, den);
			den_s[0] <= den;
			neg_s[0] <= num[N-1];
			for (int i = 1; i < N; i++) begin
				{rem_s[i], dq_s[i]} <= div_step(rem_s[i-1], dq_s[i-1], den_s[i-1]);
				neg_s[i] <= neg_s[i-1];
			end
			for (int i = 1; i < N-1; i++)
				den_s[i] <= den_s[i-1];
		end
	end

	// negative with remainder: -(q+1) = ~q
	always_comb begin
		if (!neg_s[N-1])
			quo = dq_s[N-1];
		else if (rem_s[N-1] != '0)
			quo = ~dq_s[N-1];
		else
			quo = 32'd0 - dq_s[N-1];
	end

endmodule

// ===== rtl/spatial_hash_grid_key_core.sv =====
// Spatial hash grid key core: floor division, wrap and linearize of one
// 3D position per cycle while the output is not stalled. Uses shgk_pkg and shgk_div.
//
//  channel | signals                            | handshake
//  in      | pos_x pos_y pos_z                  | in_valid / in_ready
//  out     | hash_key cell_x cell_y cell_z      | out_valid / out_ready
//  cfg     | cfg_we cfg_idx cfg_data            | write on cfg_we
//
// One request per cycle unless stalled. The pipe has 32 divider stages, a quotient
// and a magnitude stage, 16 remainder stages of two bits each, wrap, partial key
// and the output register.
// The whole pipe advances when the output register is free or taken; a stall
// freezes every stage, so nothing is lost or repeated.
// Reset clears valid bits and loads default register values.
module spatial_hash_grid_key_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [shgk_pkg::POS_W-1:0] pos_x,
	input  logic signed [shgk_pkg::POS_W-1:0] pos_y,
	input  logic signed [shgk_pkg::POS_W-1:0] pos_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [shgk_pkg::KEY_W-1:0]        hash_key,
	output logic signed [shgk_pkg::POS_W-1:0] cell_x,
	output logic signed [shgk_pkg::POS_W-1:0] cell_y,
	output logic signed [shgk_pkg::POS_W-1:0] cell_z,
	input  logic                              cfg_we,
	input  logic [shgk_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [shgk_pkg::CFG_DAT_W-1:0]    cfg_data
);
	import shgk_pkg::*;

	localparam int DLAT = POS_W;
	localparam int MLAT = POS_W / 2;
	localparam int NV   = DLAT + MLAT + 5;

	logic [31:0] spacing_q;
	logic [10:0] rx_q, ry_q, rz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= 32'd65536;
			rx_q      <= 11'd64;
			ry_q      <= 11'd64;
			rz_q      <= 11'd64;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SPACING: spacing_q <= cfg_data;
				REG_RES_X:   rx_q      <= cfg_data[10:0];
				REG_RES_Y:   ry_q      <= cfg_data[10:0];
				REG_RES_Z:   rz_q      <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	logic [31:0] den;
	res_t        er [3];
	assign den   = (spacing_q == 32'd0) ? 32'd1 : spacing_q;
	assign er[0] = eff_res(rx_q);
	assign er[1] = eff_res(ry_q);
	assign er[2] = eff_res(rz_q);

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	logic [NV-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[NV-2:0], in_valid};
	end
	assign out_valid = vld_q[NV-1];

	logic signed [POS_W-1:0] qx, qy, qz;
	shgk_div u_dx (.clk, .en(adv), .num(pos_x), .den(den), .quo(qx));
	shgk_div u_dy (.clk, .en(adv), .num(pos_y), .den(den), .quo(qy));
	shgk_div u_dz (.clk, .en(adv), .num(pos_z), .den(den), .quo(qz));

	// one restoring remainder step: shift in bit b, subtract r when it fits
	function automatic res_t rem_step(input res_t m, input logic b, input res_t r);
		logic [RES_W:0] sh;
		logic [RES_W:0] trial;
		sh       = {m, b};
		trial    = sh - {1'b0, r};
		rem_step = trial[RES_W] ? sh[RES_W-1:0] : trial[RES_W-1:0];
	endfunction

	// stage 1: register the floor quotients
	logic signed [POS_W-1:0] c_s1 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1[0] <= qx;
			c_s1[1] <= qy;
			c_s1[2] <= qz;
		end
	end

	// stage 2: magnitude of each cell coordinate
	logic signed [POS_W-1:0] c_s2 [3];
	logic [POS_W-1:0]        a_s2 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				c_s2[a] <= c_s1[a];
				a_s2[a] <= c_s1[a][POS_W-1] ? (32'd0 - c_s1[a]) : c_s1[a];
			end
		end
	end

	// remainder pipe: magnitude mod resolution, two bits per stage
	logic signed [POS_W-1:0] cm_s [3][MLAT];
	logic [POS_W-1:0]        um_s [3][MLAT-1];
	res_t                    rm_s [3][MLAT];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				cm_s[a][0] <= c_s2[a];
				um_s[a][0] <= a_s2[a] << 2;
				rm_s[a][0] <= rem_step(rem_step('0, a_s2[a][POS_W-1], er[a]),
					a_s2[a][POS_W-2], er[a]);
				for (int i = 1; i < MLAT; i++) begin
					cm_s[a][i] <= cm_s[a][i-1];
					rm_s[a][i] <= rem_step(
						rem_step(rm_s[a][i-1], um_s[a][i-1][POS_W-1], er[a]),
						um_s[a][i-1][POS_W-2], er[a]);
				end
				for (int i = 1; i < MLAT-1; i++)
					um_s[a][i] <= um_s[a][i-1] << 2;
			end
		end
	end

	// stage 3: a negative cell with a remainder wraps down from the top
	logic signed [POS_W-1:0] c_s3 [3];
	res_t                    w_s3 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				c_s3[a] <= cm_s[a][MLAT-1];
				w_s3[a] <= (cm_s[a][MLAT-1][POS_W-1] && rm_s[a][MLAT-1] != '0) ?
					er[a] - rm_s[a][MLAT-1] : rm_s[a][MLAT-1];
			end
		end
	end

	logic signed [POS_W-1:0] cx_s4, cy_s4, cz_s4;
	logic [2*RES_W:0] t_s4;
	res_t wx_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s4 <= c_s3[0]; cy_s4 <= c_s3[1]; cz_s4 <= c_s3[2];
			t_s4  <= (2*RES_W+1)'(w_s3[2]) * (2*RES_W+1)'(er[1]) +
				(2*RES_W+1)'(w_s3[1]);
			wx_s4 <= w_s3[0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_x   <= cx_s4; cell_y <= cy_s4; cell_z <= cz_s4;
			hash_key <= KEY_W'((3*RES_W+1)'(t_s4) * (3*RES_W+1)'(er[0]) +
				(3*RES_W+1)'(wx_s4));
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hash_key))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("ready not tied to output slot");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted request lost");

endmodule

// ===== tb/tb_spatial_hash_grid_key_core.sv =====
`timescale 1ns / 100ps
// Testbench for spatial_hash_grid_key_core: random and directed positions
// against a built-in bucket-key predictor. Depends on shgk_pkg and the core.
module tb_spatial_hash_grid_key_core;
	import shgk_pkg::*;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} pos_t;

	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic signed [POS_W-1:0] cx;
		logic signed [POS_W-1:0] cy;
		logic signed [POS_W-1:0] cz;
	} bucket_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic [KEY_W-1:0] hash_key;
	logic signed [POS_W-1:0] cell_x, cell_y, cell_z;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DAT_W-1:0] cfg_data;

	spatial_hash_grid_key_core dut (.*);

	// Predictor copy of the registers
	logic [31:0] spacing_q;
	logic [10:0] rx_q, ry_q, rz_q;

	pos_t    pending_pos[$];
	bucket_t expected_buckets[$];
	int      mismatches = 0;
	int      n_results = 0;
	int      n_cfg = 0;
	bit      driver_on;
	int      burst_left, gap_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic queue_pos(input pos_t p);
		pending_pos.insert(pending_pos.size(), p);
	endtask

	function automatic longint eff_axis(input logic [10:0] r);
		if (r == 0)
			return 1;
		if (r > (11'd1 << RES_BITS))
			return longint'(1) << RES_BITS;
		return longint'(r);
	endfunction

	function automatic longint floor_ratio(input longint p, input longint s);
		longint q;
		q = p / s;
		if ((p % s) != 0 && p < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint wrap_axis(input longint q, input longint r);
		longint m;
		m = q % r;
		if (m < 0)
			m = m + r;
		return m;
	endfunction

	function automatic bucket_t bucket_of(input pos_t p);
		longint s, ax, ay, az, cx, cy, cz, k;
		bucket_t b;
		s  = (spacing_q == 0) ? 1 : longint'(spacing_q);
		ax = eff_axis(rx_q);
		ay = eff_axis(ry_q);
		az = eff_axis(rz_q);
		cx = floor_ratio(longint'(p.x), s);
		cy = floor_ratio(longint'(p.y), s);
		cz = floor_ratio(longint'(p.z), s);
		k  = (wrap_axis(cz, az) * ay + wrap_axis(cy, ay)) * ax +
			wrap_axis(cx, ax);
		b.key = k[KEY_W-1:0];
		b.cx  = cx[31:0];
		b.cy  = cy[31:0];
		b.cz  = cz[31:0];
		return b;
	endfunction

	// Driver: bursts with random gaps; payload held until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			pos_x      <= '0;
			pos_y      <= '0;
			pos_z      <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			automatic bit fire = in_valid && in_ready;
			automatic pos_t nxt;
			if (fire) begin
				expected_buckets.insert(expected_buckets.size(),
					bucket_of(pending_pos[0]));
				void'(pending_pos.pop_front());
			end
			if (!in_valid || fire) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (driver_on && pending_pos.size() > 0) begin
					nxt = pending_pos[0];
					in_valid <= 1'b1;
					pos_x    <= nxt.x;
					pos_y    <= nxt.y;
					pos_z    <= nxt.z;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 :
							$urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern: phases of free flow, light stalling and heavy stalling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			automatic int mode = (n_results / 97) % 3;
			if (mode == 0)
				out_ready <= 1'b1;
			else if (mode == 1)
				out_ready <= ($urandom_range(0, 3) != 0);
			else
				out_ready <= ($urandom_range(0, 2) == 0);
		end
	end

	// Monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			automatic bucket_t got = {hash_key, cell_x, cell_y, cell_z};
			automatic bucket_t exp_b;
			n_results <= n_results + 1;
			if (expected_buckets.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result key=%0d cell=%0d,%0d,%0d",
						hash_key, cell_x, cell_y, cell_z);
			end else begin
				exp_b = expected_buckets.pop_front();
				if (got !== exp_b) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) begin
						$display("mismatch exp key=%0d cell=%0d,%0d,%0d",
							exp_b.key, exp_b.cx, exp_b.cy, exp_b.cz);
						$display("         got key=%0d cell=%0d,%0d,%0d",
							hash_key, cell_x, cell_y, cell_z);
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we   <= 1'b0;
		case (idx)
			REG_SPACING: spacing_q = val;
			REG_RES_X:   rx_q = val[10:0];
			REG_RES_Y:   ry_q = val[10:0];
			REG_RES_Z:   rz_q = val[10:0];
			default: ;
		endcase
		n_cfg++;
	endtask

	// Send the queued positions, wait for the pipe to drain, then settle before reconfiguring
	task automatic drain;
		driver_on = 1'b1;
		while (pending_pos.size() > 0 || in_valid || expected_buckets.size() > 0)
			@(posedge clk);
		driver_on = 1'b0;
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord(input logic [31:0] sp);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($urandom_range(0, 3)) * sp + 32'($urandom_range(0, 2)) - 1;
			2: return -(32'($urandom_range(0, 3)) * sp) - 32'($urandom_range(0, 1));
			3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed(16'($urandom)) * 97);
		endcase
	endfunction

	function automatic pos_t rand_pos(input logic [31:0] sp);
		pos_t p;
		p.x = rand_coord(sp);
		p.y = rand_coord(sp);
		p.z = rand_coord(sp);
		return p;
	endfunction

	initial begin
		logic [31:0] sp_set[8];
		logic [10:0] res_set[8];
		pos_t p;
		arst_n     = 1'b0;
		cfg_we = 1'b0; cfg_idx = REG_SPACING; cfg_data = '0;
		driver_on  = 1'b0;
		spacing_q  = 32'd65536;
		rx_q = 11'd64; ry_q = 11'd64; rz_q = 11'd64;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, field extremes, bit patterns
		queue_pos('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0});
		queue_pos('{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1});
		queue_pos('{32'sd65536, -32'sd65536, -32'sd65537});
		queue_pos('{32'sh5555_5555, 32'shAAAA_AAAA, 32'shFFFF_FFFF});
		queue_pos('{32'shAAAA_AAAA, 32'sh5555_5555, 32'sd1});
		drain();
		// Zero spacing, zero resolution, oversize resolution
		write_reg(REG_SPACING, 32'd0);
		write_reg(REG_RES_X, 11'd0);
		write_reg(REG_RES_Y, 11'h7FF);
		write_reg(REG_RES_Z, 11'd1025);
		queue_pos('{32'sh7FFF_FFFF, -32'sd1, -32'sd1025});
		queue_pos('{32'sh8000_0000, 32'sd1024, 32'sd1023});
		queue_pos('{-32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF});
		drain();
		// Largest spacing and the upper resolution limit
		write_reg(REG_SPACING, 32'hFFFF_FFFF);
		write_reg(REG_RES_X, 11'd1024);
		write_reg(REG_RES_Y, 11'd1024);
		write_reg(REG_RES_Z, 11'd1024);
		queue_pos('{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1});
		queue_pos('{32'sd0, 32'sh8000_0001, 32'sd5});
		drain();
		write_reg(REG_SPACING, 32'd1);
		queue_pos('{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1048577});
		queue_pos('{-32'sd1, 32'sd1048576, 32'sd3});
		drain();

		// Random phases under a range of settings
		sp_set  = '{32'd1, 32'd65536, 32'd3, 32'h0000_8000, 32'd40000,
			32'h0123_4567, 32'hFFFF_FFFF, 32'd0};
		res_set = '{11'd1, 11'd64, 11'd1024, 11'd7, 11'd0, 11'h7FF, 11'd1000, 11'd33};
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(REG_SPACING, (ph % 4 == 3) ? $urandom : sp_set[ph % 8]);
			write_reg(REG_RES_X, ($urandom_range(0, 3) == 0) ? 11'($urandom) :
				res_set[$urandom_range(0, 7)]);
			write_reg(REG_RES_Y, res_set[$urandom_range(0, 7)]);
			write_reg(REG_RES_Z, ($urandom_range(0, 3) == 0) ? 11'($urandom) :
				res_set[$urandom_range(0, 7)]);
			for (int i = 0; i < 152; i++) begin
				p = rand_pos(spacing_q == 0 ? 32'd1 : spacing_q);
				queue_pos(p);
			end
			drain();
		end

		$display("covered %0d positions over %0d register writes, random idle and stall",
			n_results, n_cfg);
		if (mismatches == 0)
			$display("[spatial_hash_grid_key_core] OK");
		else
			$display("[spatial_hash_grid_key_core] ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout waiting for results");
		$display("[spatial_hash_grid_key_core] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/shgk_pkg.sv
rtl/shgk_div.sv
rtl/spatial_hash_grid_key_core.sv
tb/tb_spatial_hash_grid_key_core.sv
